// ===== rtl/core/sorted_alarm_queue_unit_macros.svh =====
// Assertion macros used by the sorted alarm queue top level.
`ifndef SORTED_ALARM_QUEUE_UNIT_MACROS_SVH
`define SORTED_ALARM_QUEUE_UNIT_MACROS_SVH

// Checks that the condition holds at every clock edge outside reset.
`define SAQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Checks that the consequence holds in the cycle after the antecedent.
`define SAQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/saq_pkg.sv =====
// Types and constants shared by the sorted alarm queue cells and top level.
package saq_pkg;

  localparam int unsigned SaqDepth   = 16;
  localparam int unsigned SaqCntW    = $clog2(SaqDepth + 1);
  localparam int unsigned SaqWhenW   = 38;
  localparam int unsigned SaqHandleW = 16;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StFull    = 2'd1,
    StInvalid = 2'd2,
    StEmpty   = 2'd3
  } saq_status_e;

  typedef struct packed {
    logic                  valid;
    logic [SaqWhenW-1:0]   when;
    logic [SaqHandleW-1:0] handle;
  } saq_entry_t;

  typedef struct packed {
    logic       ins;
    logic       pop;
    saq_entry_t new_entry;
  } saq_ctrl_t;

endpackage

// ===== rtl/core/sorted_alarm_queue_unit.sv =====
// Top level of the sorted alarm queue: input decode, cell chain and result register.
//
// Input channel s_axis: tuser carries the command (0 registers an alarm, 1 pops the
// head because it fired); tdata carries the alarm time and handle. Every accepted
// transaction yields exactly one result transaction on m_axis, carrying the status,
// the fired handle, the time to arm the clock alarm and the number of held alarms.
// The alarms live in a chain of slots kept in ascending time order; on an insert
// every slot compares its time with the new one in parallel and either keeps its
// entry, takes the new one or takes its neighbor's, and on a pop every slot takes
// its successor's entry. One transaction is handled per cycle while the receiver takes
// results, set by the single pass through the slot chain, and the result appears on
// m_axis in the cycle after acceptance. The result register holds its value while the
// receiver stalls, and s_axis_tready stays high while the register is empty or being
// emptied, so the input side keeps flowing unless a result is waiting. Reset empties
// all slots at once, clears the held count and drops m_axis_tvalid.
`include "sorted_alarm_queue_unit_macros.svh"

module sorted_alarm_queue_unit
  import saq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // Fields from bit 0: alarm_year[11:0], alarm_month[15:12], alarm_day[20:16],
  // alarm_hour[25:21], alarm_minute[31:26], alarm_second[37:32], alarm_handle[53:38].
  input  logic [55:0] s_axis_tdata_i,
  // Fields from bit 0: command[0].
  input  logic        s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // Fields from bit 0: fired_handle[15:0], arm_year[27:16], arm_month[31:28],
  // arm_day[36:32], arm_hour[41:37], arm_minute[47:42], arm_second[53:48],
  // entry_count[58:54].
  output logic [63:0] m_axis_tdata_o,
  // Fields from bit 0: status[1:0], fired_valid[2], arm_valid[3].
  output logic [3:0]  m_axis_tuser_o
);

  logic                  accept;
  logic                  cmd_fire;
  logic [SaqHandleW-1:0] in_handle;
  logic [SaqWhenW-1:0]   in_when;
  logic                  full;
  logic                  empty;
  saq_ctrl_t             ctrl;
  saq_entry_t            cell_q [SaqDepth];
  logic                  keep   [SaqDepth];
  logic [SaqDepth-1:0]   valid_vec;
  saq_entry_t            head_next;
  logic [SaqCntW-1:0]    count_q, count_d;
  saq_status_e           status;
  logic                  fired_valid;
  logic                  arm_valid;
  logic [SaqHandleW-1:0] fired_handle;
  logic [SaqWhenW-1:0]   arm_when;
  logic                  out_valid_q;
  logic [63:0]           out_data_q, out_data_d;
  logic [3:0]            out_user_q, out_user_d;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign cmd_fire        = s_axis_tuser_i;
  assign in_handle       = s_axis_tdata_i[53:38];
  assign in_when         = {s_axis_tdata_i[11:0], s_axis_tdata_i[15:12],
                            s_axis_tdata_i[20:16], s_axis_tdata_i[25:21],
                            s_axis_tdata_i[31:26], s_axis_tdata_i[37:32]};
  assign full            = (count_q == SaqCntW'(SaqDepth));
  assign empty           = (count_q == '0);

  always_comb begin
    ctrl.ins              = accept && !cmd_fire && (in_handle != '0) && !full;
    ctrl.pop              = accept && cmd_fire && !empty;
    ctrl.new_entry.valid  = 1'b1;
    ctrl.new_entry.when   = in_when;
    ctrl.new_entry.handle = in_handle;
  end

  for (genvar i = 0; i < SaqDepth; i++) begin : g_cell
    saq_entry_t prev_entry;
    logic       prev_keep;
    saq_entry_t succ_entry;

    if (i == 0) begin : g_head
      assign prev_entry = '0;
      assign prev_keep  = 1'b1;
    end else begin : g_body
      assign prev_entry = cell_q[i-1];
      assign prev_keep  = keep[i-1];
    end

    if (i == SaqDepth - 1) begin : g_tail
      assign succ_entry = '0;
    end else begin : g_link
      assign succ_entry = cell_q[i+1];
    end

    saq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .prev_i      (prev_entry),
      .prev_keep_i (prev_keep),
      .succ_i      (succ_entry),
      .entry_o     (cell_q[i]),
      .keep_o      (keep[i])
    );

    assign valid_vec[i] = cell_q[i].valid;
  end

  always_comb begin
    head_next = cell_q[0];
    if (ctrl.ins) begin
      head_next = keep[0] ? cell_q[0] : ctrl.new_entry;
    end else if (ctrl.pop) begin
      head_next = cell_q[1];
    end
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.ins) begin
      count_d = count_q + SaqCntW'(1);
    end else if (ctrl.pop) begin
      count_d = count_q - SaqCntW'(1);
    end
  end

  always_comb begin
    status = StOk;
    if (!cmd_fire) begin
      if (in_handle == '0) begin
        status = StInvalid;
      end else if (full) begin
        status = StFull;
      end
    end else if (empty) begin
      status = StEmpty;
    end
    fired_valid  = ctrl.pop;
    fired_handle = ctrl.pop ? cell_q[0].handle : '0;
    arm_valid    = (ctrl.ins || ctrl.pop) && head_next.valid;
    arm_when     = arm_valid ? head_next.when : '0;
    out_data_d   = {5'b0, 5'(count_d), arm_when[5:0], arm_when[11:6], arm_when[16:12],
                    arm_when[21:17], arm_when[25:22], arm_when[37:26], fired_handle};
    out_user_d   = {arm_valid, fired_valid, status};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  `SAQ_ASSERT_ALWAYS(a_count_matches, ($countones(valid_vec) == count_q), "held count differs from occupied slots")
  `SAQ_ASSERT_ALWAYS(a_slots_packed, ((valid_vec & (valid_vec + SaqDepth'(1))) == '0), "occupied slots are not packed at the head")
  `SAQ_ASSERT_NEXT(a_pop_shrinks, ctrl.pop, (count_q == $past(count_q) - SaqCntW'(1)), "pop did not reduce the held count")

endmodule

// ===== rtl/core/saq_cell.sv =====
// One slot of the sorted alarm chain: keeps, takes the new entry or shifts.
module saq_cell
  import saq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  saq_ctrl_t  ctrl_i,
  input  saq_entry_t prev_i,
  input  logic       prev_keep_i,
  input  saq_entry_t succ_i,
  output saq_entry_t entry_o,
  output logic       keep_o
);

  saq_entry_t entry_q, entry_d;

  // A valid entry stays put on insert when its time is earlier than or equal to the new one.
  assign keep_o = entry_q.valid && !(ctrl_i.new_entry.when < entry_q.when);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (!keep_o) begin
        entry_d = prev_keep_i ? ctrl_i.new_entry : prev_i;
      end
    end else if (ctrl_i.pop) begin
      entry_d = succ_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule

// ===== dv/sorted_alarm_queue_unit_tb.sv =====
// Stream testbench for the sorted alarm queue, checking every result against a mirrored queue.
`timescale 1ns / 100ps

module sorted_alarm_queue_unit_tb
  import saq_pkg::*;
();

  typedef struct packed {
    logic        command;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [15:0] handle;
  } alarm_req_t;

  typedef struct packed {
    saq_status_e status;
    logic        fired_valid;
    logic [15:0] fired_handle;
    logic        arm_valid;
    logic [37:0] arm_when;
    logic [4:0]  entry_count;
  } alarm_rsp_t;

  class alarm_order_scoreboard;
    logic [37:0] mirror_when[$];
    logic [15:0] mirror_handle[$];
    alarm_rsp_t  pending_results[$];
    int unsigned error_count = 0;
    int unsigned printed = 0;

    task report(string field, logic [63:0] got, logic [63:0] want);
      error_count++;
      if (printed < 60) begin
        printed++;
        $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, field, got, want);
      end
    endtask

    function void note_request(alarm_req_t req);
      alarm_rsp_t  rsp;
      logic [37:0] when;
      int          pos;
      rsp = '0;
      rsp.status = StOk;
      when = {req.year, req.month, req.day, req.hour, req.minute, req.second};
      if (req.command == 1'b0) begin
        if (req.handle == 16'h0000) begin
          rsp.status = StInvalid;
        end else if (mirror_when.size() >= SaqDepth) begin
          rsp.status = StFull;
        end else begin
          pos = 0;
          while (pos < mirror_when.size() && mirror_when[pos] <= when) pos++;
          mirror_when.insert(pos, when);
          mirror_handle.insert(pos, req.handle);
          rsp.arm_valid = 1'b1;
          rsp.arm_when = mirror_when[0];
        end
      end else begin
        if (mirror_when.size() == 0) begin
          rsp.status = StEmpty;
        end else begin
          rsp.fired_valid = 1'b1;
          rsp.fired_handle = mirror_handle.pop_front();
          void'(mirror_when.pop_front());
          if (mirror_when.size() > 0) begin
            rsp.arm_valid = 1'b1;
            rsp.arm_when = mirror_when[0];
          end
        end
      end
      rsp.entry_count = 5'(mirror_when.size());
      pending_results.push_back(rsp);
    endfunction

    task check_result(logic [63:0] tdata, logic [3:0] tuser);
      alarm_rsp_t want;
      if (pending_results.size() == 0) begin
        report("unexpected result", {tuser, tdata[59:0]}, '0);
      end else begin
        want = pending_results.pop_front();
        if (tuser[1:0] !== want.status) report("status", tuser[1:0], want.status);
        if (tuser[2] !== want.fired_valid) report("fired_valid", tuser[2], want.fired_valid);
        if (tuser[3] !== want.arm_valid) report("arm_valid", tuser[3], want.arm_valid);
        if (tdata[15:0] !== want.fired_handle)
          report("fired_handle", tdata[15:0], want.fired_handle);
        if (tdata[27:16] !== want.arm_when[37:26])
          report("arm_year", tdata[27:16], want.arm_when[37:26]);
        if (tdata[31:28] !== want.arm_when[25:22])
          report("arm_month", tdata[31:28], want.arm_when[25:22]);
        if (tdata[36:32] !== want.arm_when[21:17])
          report("arm_day", tdata[36:32], want.arm_when[21:17]);
        if (tdata[41:37] !== want.arm_when[16:12])
          report("arm_hour", tdata[41:37], want.arm_when[16:12]);
        if (tdata[47:42] !== want.arm_when[11:6])
          report("arm_minute", tdata[47:42], want.arm_when[11:6]);
        if (tdata[53:48] !== want.arm_when[5:0])
          report("arm_second", tdata[53:48], want.arm_when[5:0]);
        if (tdata[58:54] !== want.entry_count)
          report("entry_count", tdata[58:54], want.entry_count);
        if (tdata[63:59] !== 5'h00) report("tdata padding", tdata[63:59], 5'h00);
      end
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready_o;
  logic [55:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata_o;
  logic [3:0]  m_axis_tuser_o;

  alarm_order_scoreboard alarm_sb;
  int unsigned           accepted_count = 0;
  logic                  hold_off_done = 1'b0;
  logic [37:0]           time_pool[4];

  sorted_alarm_queue_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic alarm_req_t make_req(logic cmd, logic [37:0] when, logic [15:0] handle);
    alarm_req_t req;
    req.command = cmd;
    {req.year, req.month, req.day, req.hour, req.minute, req.second} = when;
    req.handle = handle;
    return req;
  endfunction

  function automatic logic [37:0] legal_time();
    return {12'($urandom_range(0, 4095)), 4'($urandom_range(1, 12)),
            5'($urandom_range(1, 31)), 5'($urandom_range(0, 23)),
            6'($urandom_range(0, 59)), 6'($urandom_range(0, 59))};
  endfunction

  function automatic logic [37:0] random_time();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return time_pool[$urandom_range(0, 3)];
    if (pick < 9) return legal_time();
    return {6'($urandom()), 32'($urandom())};
  endfunction

  function automatic logic [15:0] random_handle();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return 16'h0000;
    if (pick == 1) return 16'hffff;
    return 16'($urandom_range(1, 65535));
  endfunction

  task automatic send_req(alarm_req_t req);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req.command;
    s_axis_tdata  <= {2'b00, req.handle, req.second, req.minute, req.hour, req.day,
                      req.month, req.year};
    do @(posedge clk_i); while (!s_axis_tready_o);
    alarm_sb.note_request(req);
    accepted_count++;
    @(negedge clk_i);
  endtask

  task automatic idle_sender(int unsigned cycles);
    s_axis_tvalid <= 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  initial begin
    int unsigned cycle;
    int unsigned mode;
    m_axis_tready = 1'b0;
    cycle = 0;
    mode = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      cycle++;
      if (!hold_off_done && accepted_count >= 300) begin
        m_axis_tready <= 1'b0;
        repeat (399) @(negedge clk_i);
        hold_off_done = 1'b1;
      end else begin
        if (cycle % 200 == 0) mode = $urandom_range(0, 3);
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= ($urandom_range(0, 9) < 7);
          2: m_axis_tready <= ($urandom_range(0, 9) < 3);
          default: m_axis_tready <= (cycle % 7 != 0);
        endcase
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid_o && m_axis_tready)
        alarm_sb.check_result(m_axis_tdata_o, m_axis_tuser_o);
    end
  end

  initial begin
    int          i;
    int          burst_left;
    int unsigned register_pct;
    alarm_req_t  req;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    alarm_sb = new();
    for (i = 0; i < 4; i++) time_pool[i] = legal_time();
    @(posedge rst_ni);
    @(negedge clk_i);

    send_req(make_req(1'b1, '0, 16'h0000));
    send_req(make_req(1'b0, '1, 16'h0000));
    send_req(make_req(1'b0, '1, 16'hffff));
    send_req(make_req(1'b0, '0, 16'h0001));
    send_req(make_req(1'b1, '1, 16'hffff));
    send_req(make_req(1'b1, '0, 16'h0000));
    for (i = 0; i < 16; i++) send_req(make_req(1'b0, time_pool[i % 4], 16'(16'h0100 + i)));
    send_req(make_req(1'b0, '0, 16'h0005));
    send_req(make_req(1'b0, '0, 16'h0000));

    burst_left = 0;
    register_pct = 50;
    for (i = 0; i < 2000; i++) begin
      if (i % 64 == 0) begin
        case ($urandom_range(0, 2))
          0: register_pct = 85;
          1: register_pct = 50;
          default: register_pct = 20;
        endcase
      end
      if (burst_left == 0) begin
        idle_sender($urandom_range(1, 12));
        burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 20);
      end
      burst_left--;
      req = make_req(($urandom_range(0, 99) >= register_pct), random_time(), random_handle());
      send_req(req);
    end
    s_axis_tvalid <= 1'b0;

    while (alarm_sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (alarm_sb.error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
